@@ rtl/fspa_pkg.sv @@
package fspa_pkg;

  // Default number of slots held in the pool memories.
  localparam int SLOTS_DEF = 256;

  // Register reset values.
  localparam int UNIT_COUNT_RST = 256;
  localparam int UNIT_SIZE_RST  = 1;

  localparam int UNIT_COUNT_W = 9;
  localparam int UNIT_SIZE_W  = 12;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_SIZE  = 1'b1;

  // Operation codes.
  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_REINIT = 2'd2;

  // Status codes.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_EMPTY    = 2'd1;
  localparam logic [1:0] STAT_RANGE    = 2'd2;
  localparam logic [1:0] STAT_NOT_USED = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] freed_slot;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  given_slot;
    logic [20:0] data_offset;
    logic [8:0]  free_left;
  } out_word_t;

endpackage

@@ rtl/fspa_ram.sv @@
module fspa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/fixed_slot_pool_allocator.sv @@
// Fixed-size slot pool. Each input word asks to allocate a slot, free a slot
// or rebuild the pool, and yields exactly one result word holding a status,
// the slot handed out, the byte offset of its data (slot*(1+unit_size)+1)
// and the number of free slots left. The free-slot stack and the in-use bits
// live in two single-port-read memories with a registered read; the
// stack top is a register. For an allocate, free or unused code the
// memories are read in the cycle the word is accepted, and the result is
// settled and any write-back done in the execute state once the output
// register is free. A reinitialise sweeps both memories one entry a cycle.
// After reset the same sweep runs with in_stall high before the first word
// is taken; configuration writes are accepted throughout. A finished result
// sits in the output register while the next word is accepted, so a stalled
// output side costs nothing until a second result is ready.
module fixed_slot_pool_allocator #(
  parameter int SLOTS = fspa_pkg::SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  fspa_pkg::in_word_t                  in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output fspa_pkg::out_word_t                 out_word,
  input  logic                                cfg_we,
  input  logic [fspa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fspa_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import fspa_pkg::*;

  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int CMP_W   = (CNT_W > UNIT_COUNT_W) ? CNT_W : UNIT_COUNT_W;
  localparam int RST_TOP = (UNIT_COUNT_RST > SLOTS) ? SLOTS : UNIT_COUNT_RST;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SWEEP = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t                  state_r, state_nxt;
  logic [UNIT_COUNT_W-1:0] unit_count_r;
  logic [UNIT_SIZE_W-1:0]  unit_size_r;
  logic [CNT_W-1:0]        free_top_r, free_top_nxt;
  logic [SLOT_W-1:0]       sweep_cnt_r, sweep_cnt_nxt;
  logic                    sweep_rst_r, sweep_rst_nxt;
  logic [1:0]              op_r;
  logic [7:0]              slot_r;
  logic                    out_valid_r, out_valid_nxt;
  out_word_t               out_word_r;

  logic              accept;
  logic              commit;
  logic [CNT_W-1:0]  top_dec;
  logic [CMP_W-1:0]  active_c;
  logic [CMP_W-1:0]  ucnt_ext;
  logic [CMP_W-1:0]  slots_ext;
  logic [12:0]       mul_b;
  logic [7:0]        given_c;
  logic [20:0]       offset_c;
  out_word_t         res_word;

  logic              stk_we;
  logic [SLOT_W-1:0] stk_waddr;
  logic [SLOT_W-1:0] stk_wdata;
  logic [SLOT_W-1:0] stk_raddr;
  logic [SLOT_W-1:0] stk_rdata;
  logic              use_we;
  logic [SLOT_W-1:0] use_waddr;
  logic [0:0]        use_wdata;
  logic [SLOT_W-1:0] use_raddr;
  logic [0:0]        use_rdata;

  // Words are taken only when the sequencer is idle; both memories are read
  // speculatively at that edge, the stack at the current top and the in-use
  // bit at the slot named for release.
  assign accept    = in_valid && (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE);
  assign top_dec   = free_top_r - CNT_W'(1);
  assign stk_raddr = top_dec[SLOT_W-1:0];
  assign use_raddr = SLOT_W'(in_word.freed_slot);

  // The result leaves the execute state once the output register is free.
  assign commit = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  // Slots in service: unit_count clipped to the size of the memories.
  assign ucnt_ext  = CMP_W'(unit_count_r);
  assign slots_ext = CMP_W'(SLOTS);
  assign active_c  = (ucnt_ext > slots_ext) ? slots_ext : ucnt_ext;

  // Data offset of the popped slot; one header byte precedes each slot.
  assign given_c  = 8'(stk_rdata);
  assign mul_b    = 13'(unit_size_r) + 13'd1;
  assign offset_c = 21'({13'd0, given_c} * {8'd0, mul_b}) + 21'd1;

  always_comb begin
    state_nxt     = state_r;
    free_top_nxt  = free_top_r;
    sweep_cnt_nxt = sweep_cnt_r;
    sweep_rst_nxt = sweep_rst_r;
    out_valid_nxt = out_valid_r && out_stall;

    stk_we    = 1'b0;
    stk_waddr = free_top_r[SLOT_W-1:0];
    stk_wdata = SLOT_W'(slot_r);
    use_we    = 1'b0;
    use_waddr = SLOT_W'(slot_r);
    use_wdata = 1'b0;

    res_word             = '0;
    res_word.status      = STAT_OK;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_word.op == OP_REINIT) begin
            state_nxt     = S_SWEEP;
            sweep_cnt_nxt = '0;
            sweep_rst_nxt = 1'b0;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_SWEEP: begin
        // Entry i of the stack gets slot i and every slot is marked free.
        stk_we    = 1'b1;
        stk_waddr = sweep_cnt_r;
        stk_wdata = sweep_cnt_r;
        use_we    = 1'b1;
        use_waddr = sweep_cnt_r;
        use_wdata = 1'b0;
        sweep_cnt_nxt = sweep_cnt_r + SLOT_W'(1);
        if (sweep_cnt_r == SLOT_W'(SLOTS - 1)) begin
          sweep_cnt_nxt = '0;
          sweep_rst_nxt = 1'b0;
          if (sweep_rst_r) begin
            state_nxt = S_IDLE;
          end else begin
            free_top_nxt = CNT_W'(active_c);
            state_nxt    = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        if (commit) begin
          case (op_r)
            OP_ALLOC: begin
              if (free_top_r == '0) begin
                res_word.status = STAT_EMPTY;
              end else begin
                use_we                = 1'b1;
                use_waddr             = stk_rdata;
                use_wdata             = 1'b1;
                free_top_nxt          = top_dec;
                res_word.given_slot   = given_c;
                res_word.data_offset  = offset_c;
              end
            end
            OP_FREE: begin
              if (CMP_W'(slot_r) >= active_c) begin
                res_word.status = STAT_RANGE;
              end else if (!use_rdata[0]) begin
                res_word.status = STAT_NOT_USED;
              end else begin
                use_we    = 1'b1;
                use_wdata = 1'b0;
                if (free_top_r < CNT_W'(SLOTS)) begin
                  stk_we       = 1'b1;
                  free_top_nxt = free_top_r + CNT_W'(1);
                end
              end
            end
            default: begin
              // Reinitialise (already swept) and the unused code report ok.
              res_word.status = STAT_OK;
            end
          endcase
          res_word.free_left = 9'(free_top_nxt);
          out_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      free_top_r  <= CNT_W'(RST_TOP);
      sweep_cnt_r <= '0;
      sweep_rst_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_top_r  <= free_top_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      sweep_rst_r <= sweep_rst_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_count_r <= UNIT_COUNT_W'(UNIT_COUNT_RST);
      unit_size_r  <= UNIT_SIZE_W'(UNIT_SIZE_RST);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_UNIT_COUNT: unit_count_r <= cfg_data[UNIT_COUNT_W-1:0];
        CFG_UNIT_SIZE:  unit_size_r  <= cfg_data[UNIT_SIZE_W-1:0];
        default:        unit_size_r  <= unit_size_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_word.op;
      slot_r <= in_word.freed_slot;
    end
    if (commit) begin
      out_word_r <= res_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  fspa_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (accept),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  fspa_ram #(
    .WIDTH (1),
    .DEPTH (SLOTS)
  ) u_use_ram (
    .clk   (clk),
    .we    (use_we),
    .waddr (use_waddr),
    .wdata (use_wdata),
    .re    (accept),
    .raddr (use_raddr),
    .rdata (use_rdata)
  );

endmodule

@@ rtl/fspa_checker.sv @@
module fspa_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input fspa_pkg::out_word_t out_word
);

  import fspa_pkg::*;

  // A held result word must not change or vanish.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // One word is worked on at a time, so the input stalls after each accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after an accepted word");

  // An empty pool is only reported when no slot is free.
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status == STAT_EMPTY) |-> (out_word.free_left == 9'd0))
    else $error("empty status with free slots left");

  // Failed operations hand nothing out.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status != STAT_OK)
      |-> (out_word.given_slot == 8'd0) && (out_word.data_offset == 21'd0))
    else $error("failed operation returned a slot or offset");

endmodule

bind fixed_slot_pool_allocator fspa_checker u_fspa_checker (.*);
